// ----- rtl/i4bs_pkg.sv -----
package i4bs_pkg;

  localparam int unsigned TILE_EDGE   = 32;
  localparam int unsigned MAX_K_TILES = 128;
  localparam int unsigned MAX_N_TILES = 128;

  localparam int unsigned TILE_W    = 8;
  localparam int unsigned PAIR_W    = 11;
  localparam int unsigned COL_W     = 12;
  localparam int unsigned ADDR_W    = 24;
  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned CFG_DW    = 32;

  typedef enum logic [0:0] {
    REG_K_TILES = 1'b0,
    REG_N_TILES = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest_address;
    logic              is_last;
  } addr_info_t;

  typedef struct packed {
    logic signed [7:0] even_value;
    logic signed [7:0] odd_value;
    logic [ADDR_W-1:0] dest_address;
    logic              is_last;
  } result_t;

  // zero behaves as one, anything above the maximum as the maximum
  function automatic logic [TILE_W-1:0] clamp_tiles(input logic [TILE_W-1:0] v,
                                                    input logic [TILE_W-1:0] maxv);
    logic [TILE_W-1:0] res;
    if (v == '0) begin
      res = TILE_W'(1);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ----- rtl/i4bs_lane.sv -----
module i4bs_lane (
  input  logic [3:0]        nibble,
  input  logic [7:0]        scale,
  output logic signed [7:0] value
);

  logic signed [12:0] product;

  always_comb begin
    product = 13'($signed(nibble) * $signed({1'b0, scale}));
    if (product < -13'sd128) begin
      value = -8'sd128;
    end else if (product > 13'sd127) begin
      value = 8'sd127;
    end else begin
      value = product[7:0];
    end
  end

endmodule

// ----- rtl/i4bs_addr.sv -----
module i4bs_addr (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             advance,
  input  logic [i4bs_pkg::TILE_W-1:0]      kt_eff,
  input  logic [i4bs_pkg::TILE_W-1:0]      nt_eff,
  output i4bs_pkg::addr_info_t             info
);

  logic [i4bs_pkg::PAIR_W-1:0] pair_row_r, pair_row_nxt;
  logic [i4bs_pkg::COL_W-1:0]  column_r, column_nxt;
  logic [i4bs_pkg::PAIR_W:0]   last_pair_wide;
  logic [i4bs_pkg::COL_W:0]    last_col_wide;
  logic                        row_end;
  logic                        tensor_end;
  logic [14:0]                 tile_prod;
  logic [15:0]                 tile_idx;

  always_comb begin
    last_pair_wide = {kt_eff, 4'b0000} - 12'd1;
    last_col_wide  = {nt_eff, 5'b00000} - 13'd1;
    row_end    = column_r >= last_col_wide[i4bs_pkg::COL_W-1:0];
    tensor_end = row_end && (pair_row_r >= last_pair_wide[i4bs_pkg::PAIR_W-1:0]);

    tile_prod = 15'(pair_row_r[10:4]) * 15'(nt_eff);
    tile_idx  = {1'b0, tile_prod} + {9'b0, column_r[11:5]};
    // within a tile: four rows interleaved per column, 128 bytes per row group
    info.dest_address = {tile_idx[13:0], pair_row_r[3:1], column_r[4:0], pair_row_r[0], 1'b0};
    info.is_last      = tensor_end;

    pair_row_nxt = pair_row_r;
    column_nxt   = column_r;
    if (advance) begin
      if (row_end) begin
        column_nxt   = '0;
        pair_row_nxt = tensor_end ? '0 : pair_row_r + 11'd1;
      end else begin
        column_nxt = column_r + 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_row_r <= '0;
      column_r   <= '0;
    end else begin
      pair_row_r <= pair_row_nxt;
      column_r   <= column_nxt;
    end
  end

endmodule

// ----- rtl/int4_block_scale_expand_to_i8.sv -----
// Block-scaled int4 to int8 weight expander.
// Input channel (in_*): one packed byte per transaction, two signed nibbles
// (low = even K row, high = odd K row) with the unsigned block scale, in
// storage order: all columns of a pair row, then the next pair row.
// Output channel (out_*): both saturated int8 products, the tiled byte address
// of the even value (odd value at address + 1) and a flag on the final byte.
// Two lanes expand the nibbles side by side; an address unit walks the pair
// row and column counters; the merge stage registers the result.
// The result is registered in the output register, or in the skid register while the output is held.
// Throughput: one transaction per cycle while in_stall is low.
// A skid register holds one result when out_stall is raised; in_stall rises
// only once it is occupied, so no transaction is lost.
// APB port: k_tiles at 0x0, n_tiles at 0x4 (zero acts as one, values above
// 128 act as 128). Rewriting a register does not reset the counters.
// Reset (rst_n low, synchronous): both registers read 1, counters go to the
// first byte of the tensor and the output side is emptied.
module int4_block_scale_expand_to_i8 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_packed_byte,
  input  logic [7:0]                        in_block_scale,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [7:0]                 out_even_value,
  output logic signed [7:0]                 out_odd_value,
  output logic [i4bs_pkg::ADDR_W-1:0]       out_dest_address,
  output logic                              out_is_last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [i4bs_pkg::CFG_AW-1:0]       paddr,
  input  logic [i4bs_pkg::CFG_DW-1:0]       pwdata,
  output logic [i4bs_pkg::CFG_DW-1:0]       prdata,
  output logic                              pready
);

  logic [i4bs_pkg::TILE_W-1:0] k_tiles_r, k_tiles_nxt;
  logic [i4bs_pkg::TILE_W-1:0] n_tiles_r, n_tiles_nxt;
  logic [i4bs_pkg::TILE_W-1:0] kt_eff, nt_eff;
  i4bs_pkg::reg_idx_t          reg_sel;
  logic                        cfg_wr;

  logic                        accept;
  logic signed [7:0]           even_val, odd_val;
  i4bs_pkg::addr_info_t        addr_info;
  i4bs_pkg::result_t           new_res;

  i4bs_pkg::result_t           out_r, out_nxt;
  logic                        out_valid_r, out_valid_nxt;
  i4bs_pkg::result_t           skid_r, skid_nxt;
  logic                        skid_valid_r, skid_valid_nxt;

  // configuration
  assign pready  = 1'b1;
  assign reg_sel = i4bs_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    k_tiles_nxt = k_tiles_r;
    n_tiles_nxt = n_tiles_r;
    prdata      = '0;
    case (reg_sel)
      i4bs_pkg::REG_K_TILES: begin
        prdata = {24'b0, k_tiles_r};
        if (cfg_wr) k_tiles_nxt = pwdata[7:0];
      end
      i4bs_pkg::REG_N_TILES: begin
        prdata = {24'b0, n_tiles_r};
        if (cfg_wr) n_tiles_nxt = pwdata[7:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign kt_eff = i4bs_pkg::clamp_tiles(k_tiles_r, i4bs_pkg::TILE_W'(i4bs_pkg::MAX_K_TILES));
  assign nt_eff = i4bs_pkg::clamp_tiles(n_tiles_r, i4bs_pkg::TILE_W'(i4bs_pkg::MAX_N_TILES));

  // datapath
  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;

  i4bs_lane u_lane_even (
    .nibble (in_packed_byte[3:0]),
    .scale  (in_block_scale),
    .value  (even_val)
  );

  i4bs_lane u_lane_odd (
    .nibble (in_packed_byte[7:4]),
    .scale  (in_block_scale),
    .value  (odd_val)
  );

  i4bs_addr u_addr (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept),
    .kt_eff  (kt_eff),
    .nt_eff  (nt_eff),
    .info    (addr_info)
  );

  always_comb begin
    new_res.even_value   = even_val;
    new_res.odd_value    = odd_val;
    new_res.dest_address = addr_info.dest_address;
    new_res.is_last      = addr_info.is_last;

    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = new_res;
        out_valid_nxt = accept;
      end
    end else if (accept) begin
      // output held: park the transaction in the skid slot
      skid_nxt       = new_res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_tiles_r    <= 8'd1;
      n_tiles_r    <= 8'd1;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      k_tiles_r    <= k_tiles_nxt;
      n_tiles_r    <= n_tiles_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_even_value   = out_r.even_value;
  assign out_odd_value    = out_r.odd_value;
  assign out_dest_address = out_r.dest_address;
  assign out_is_last      = out_r.is_last;

endmodule

// ----- sim/tb_int4_block_scale_expand_to_i8.sv -----
`timescale 1ns / 100ps

module tb_int4_block_scale_expand_to_i8;

  typedef struct packed {
    logic [7:0]          packed_byte;
    logic [7:0]          block_scale;
    logic                typed;
    i4bs_pkg::result_t   want;
  } dir_row_t;

  localparam int N_DIR       = 22;
  localparam int N_PHASES    = 9;
  localparam int RAND_TILES  = -1;
  localparam int MAX_REPORTS = 10;

  // first pair row after reset, so the address of column n is 4*n
  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{8'h00, 8'd0,   1'b1, '{8'sd0,    8'sd0,    24'd0,  1'b0}},
    '{8'h77, 8'd255, 1'b1, '{8'sd127,  8'sd127,  24'd4,  1'b0}},
    '{8'h88, 8'd255, 1'b1, '{8'sh80,   8'sh80,   24'd8,  1'b0}},
    '{8'h8F, 8'd1,   1'b1, '{-8'sd1,   -8'sd8,   24'd12, 1'b0}},
    '{8'h7F, 8'd127, 1'b1, '{-8'sd127, 8'sd127,  24'd16, 1'b0}},
    '{8'h18, 8'd16,  1'b1, '{8'sh80,   8'sd16,   24'd20, 1'b0}},
    '{8'h81, 8'd16,  1'b1, '{8'sd16,   8'sh80,   24'd24, 1'b0}},
    '{8'hF0, 8'd128, 1'b1, '{8'sd0,    8'sh80,   24'd28, 1'b0}},
    '{8'h0F, 8'd128, 1'b1, '{8'sh80,   8'sd0,    24'd32, 1'b0}},
    '{8'h11, 8'd127, 1'b1, '{8'sd127,  8'sd127,  24'd36, 1'b0}},
    '{8'hFF, 8'd255, 1'b1, '{8'sh80,   8'sh80,   24'd40, 1'b0}},
    '{8'h23, 8'd42,  1'b1, '{8'sd126,  8'sd84,   24'd44, 1'b0}},
    '{8'h32, 8'd43,  1'b1, '{8'sd86,   8'sd127,  24'd48, 1'b0}},
    '{8'hEE, 8'd9,   1'b1, '{-8'sd18,  -8'sd18,  24'd52, 1'b0}},
    '{8'hA5, 8'd25,  1'b1, '{8'sd125,  8'sh80,   24'd56, 1'b0}},
    '{8'h5A, 8'd26,  1'b1, '{8'sh80,   8'sd127,  24'd60, 1'b0}},
    '{8'h76, 8'd0,   1'b1, '{8'sd0,    8'sd0,    24'd64, 1'b0}},
    '{8'h9C, 8'd200, 1'b0, '0},
    '{8'h4B, 8'd3,   1'b0, '0},
    '{8'h3D, 8'd5,   1'b0, '0},
    '{8'hC6, 8'd19,  1'b0, '0},
    '{8'h69, 8'd14,  1'b0, '0}
  };

  // tile settings per phase; shrinking after a large setting leaves the
  // counters past their bounds, zero and oversize values test the clamping
  localparam int PH_K   [N_PHASES] = '{0, 3, 128, 255, 1, 128, 2, RAND_TILES, RAND_TILES};
  localparam int PH_N   [N_PHASES] = '{0, 1, 128, 255, 1, 200, 2, RAND_TILES, RAND_TILES};
  localparam int PH_LEN [N_PHASES] = '{500, 560, 150, 80, 60, 60, 90, 60, 60};

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic [7:0]                        in_packed_byte;
  logic [7:0]                        in_block_scale;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [7:0]                 out_even_value;
  logic signed [7:0]                 out_odd_value;
  logic [i4bs_pkg::ADDR_W-1:0]       out_dest_address;
  logic                              out_is_last;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [i4bs_pkg::CFG_AW-1:0]       paddr;
  logic [i4bs_pkg::CFG_DW-1:0]       pwdata;
  logic [i4bs_pkg::CFG_DW-1:0]       prdata;
  logic                              pready;

  logic [7:0]                        k_tiles_set;
  logic [7:0]                        n_tiles_set;
  logic [i4bs_pkg::PAIR_W-1:0]       pair_row;
  logic [i4bs_pkg::COL_W-1:0]        column;
  i4bs_pkg::result_t                 pending_expansions [$];
  bit                                no_gaps;
  int                                errors;
  int                                n_checked;
  int                                n_tensor_ends;
  int                                n_settings;

  int4_block_scale_expand_to_i8 DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", pending_expansions.size());
    $display("int4_block_scale_expand_to_i8 regression: fail");
    $finish;
  end

  function automatic int effective_tiles(logic [7:0] v, int limit);
    int res;
    res = (v == 8'd0) ? 1 : ((int'(v) > limit) ? limit : int'(v));
    return res;
  endfunction

  function automatic logic signed [7:0] scaled_nibble(logic [3:0] nib, logic [7:0] sc);
    int prod;
    prod = (int'(nib) - (nib[3] ? 16 : 0)) * int'(sc);
    if (prod < -128) prod = -128;
    else if (prod > 127) prod = 127;
    return prod[7:0];
  endfunction

  // expands one byte at the current position and moves the counters on
  function automatic i4bs_pkg::result_t expand_byte(logic [7:0] pb, logic [7:0] sc);
    int                 kt;
    int                 nt;
    int                 p;
    int                 n;
    int                 r;
    int                 addr;
    logic               row_end;
    logic               tensor_end;
    i4bs_pkg::result_t  res;
    kt = effective_tiles(k_tiles_set, i4bs_pkg::MAX_K_TILES);
    nt = effective_tiles(n_tiles_set, i4bs_pkg::MAX_N_TILES);
    p = int'(pair_row);
    n = int'(column);
    r = (2 * p) % 32;
    addr = (((2 * p) / 32) * nt + n / 32) * 1024 + (r / 4) * 128 + (n % 32) * 4 + r % 4;
    res.even_value = scaled_nibble(pb[3:0], sc);
    res.odd_value = scaled_nibble(pb[7:4], sc);
    res.dest_address = addr[i4bs_pkg::ADDR_W-1:0];
    row_end = n >= nt * 32 - 1;
    tensor_end = row_end && (p >= kt * 16 - 1);
    res.is_last = tensor_end;
    if (row_end) begin
      column = '0;
      pair_row = tensor_end ? '0 : pair_row + i4bs_pkg::PAIR_W'(1);
    end else begin
      column = column + i4bs_pkg::COL_W'(1);
    end
    return res;
  endfunction

  task automatic write_tiles(i4bs_pkg::reg_idx_t idx, logic [7:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= i4bs_pkg::CFG_AW'(4 * int'(idx));
    pwdata <= {24'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == i4bs_pkg::REG_K_TILES) k_tiles_set = value;
    else n_tiles_set = value;
  endtask

  task automatic send_byte(logic [7:0] pb, logic [7:0] sc, logic typed,
                           i4bs_pkg::result_t want);
    i4bs_pkg::result_t predicted;
    while (!no_gaps && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_packed_byte <= pb;
    in_block_scale <= sc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = expand_byte(pb, sc);
    pending_expansions.push_back(typed ? want : predicted);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_expansions.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(99) < 11);
  end

  always @(posedge clk) begin
    i4bs_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_expansions.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected transaction: even %0d odd %0d addr %h last %b",
                   out_even_value, out_odd_value, out_dest_address, out_is_last);
      end else begin
        want = pending_expansions.pop_front();
        n_checked++;
        if (want.is_last) n_tensor_ends++;
        if (out_even_value !== want.even_value || out_odd_value !== want.odd_value ||
            out_dest_address !== want.dest_address || out_is_last !== want.is_last) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("mismatch %0d: exp %0d/%0d @%h last %b, got %0d/%0d @%h last %b",
                     n_checked, want.even_value, want.odd_value, want.dest_address,
                     want.is_last, out_even_value, out_odd_value, out_dest_address,
                     out_is_last);
        end
      end
    end
  end

  initial begin
    i4bs_pkg::result_t none;
    logic [7:0]        kv;
    logic [7:0]        nv;
    logic [7:0]        sc;
    int                idx;
    none = '0;
    idx = 0;
    no_gaps = 1'b0;
    errors = 0;
    n_checked = 0;
    n_tensor_ends = 0;
    n_settings = 0;
    k_tiles_set = 8'd1;
    n_tiles_set = 8'd1;
    pair_row = '0;
    column = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_packed_byte <= '0;
    in_block_scale <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++)
      send_byte(DIRECTED[i].packed_byte, DIRECTED[i].block_scale, DIRECTED[i].typed,
                DIRECTED[i].want);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_block();
      kv = (PH_K[ph] == RAND_TILES) ? 8'($urandom_range(255)) : 8'(PH_K[ph]);
      nv = (PH_N[ph] == RAND_TILES) ? 8'($urandom_range(255)) : 8'(PH_N[ph]);
      write_tiles(i4bs_pkg::REG_K_TILES, kv);
      write_tiles(i4bs_pkg::REG_N_TILES, nv);
      n_settings++;
      for (int i = 0; i < PH_LEN[ph]; i++) begin
        // one long stretch at full rate on both sides
        no_gaps = (idx >= 300 && idx < 700);
        sc = ($urandom_range(9) < 4) ? 8'($urandom_range(20)) : 8'($urandom_range(255));
        send_byte(8'($urandom_range(255)), sc, 1'b0, none);
        idx++;
      end
    end
    no_gaps = 1'b0;
    in_valid <= 1'b0;

    for (int w = 0; w < 1000 && pending_expansions.size() != 0; w++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_expansions.size() != 0) begin
      $display("%0d expected transactions never arrived", pending_expansions.size());
      errors += pending_expansions.size();
    end

    $display("%0d transactions checked (%0d directed) over %0d tile settings, %0d tensor ends",
             n_checked, N_DIR, n_settings, n_tensor_ends);
    if (errors == 0) begin
      $display("int4_block_scale_expand_to_i8 regression: pass");
    end else begin
      $display("%0d failures", errors);
      $display("int4_block_scale_expand_to_i8 regression: fail");
    end
    $finish;
  end

endmodule
